// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL, included by the skinning unit.
// Concurrent checks are compiled only for simulation.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define WVS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Check that a condition never holds outside reset.
`define WVS_NEVER(lbl, clk, rstn, cond) \
  `WVS_ASSERT(lbl, clk, rstn, !(cond))
`else
`define WVS_ASSERT(lbl, clk, rstn, prop)
`define WVS_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- sv/wvs_pkg.sv -----
// ----------------------------------------------------------------------------
// wvs_pkg
// Types and constants of the weighted vertex skinning unit.
// ----------------------------------------------------------------------------
`default_nettype none
package wvs_pkg;

  // Radicand and root widths of the quaternion w derivation
  localparam int unsigned RAD_W  = 29;
  localparam int unsigned ROOT_W = 15;
  localparam int unsigned ITER_W = 4;

  // Joint table entry: {w, qz, qy, qx, pz, py, px}
  localparam int unsigned ENTRY_W = 160;

  // Request types
  localparam logic REQ_JOINT  = 1'b0;
  localparam logic REQ_WEIGHT = 1'b1;

  // Status of the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } wvs_sqrt_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_JSQ,
    ST_JSUM,
    ST_JROOT,
    ST_WMUL1,
    ST_WU,
    ST_WMUL2,
    ST_WSUM,
    ST_WMUL3,
    ST_WACC,
    ST_EMIT
  } wvs_state_e;

endpackage
`default_nettype wire

// ----- sv/wvs_sqrt.sv -----
// ----------------------------------------------------------------------------
// wvs_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module wvs_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [wvs_pkg::RAD_W-1:0]   radicand_i,
  output wvs_pkg::wvs_sqrt_stat_t          stat_o,
  output logic [wvs_pkg::ROOT_W-1:0]       root_o
);
  import wvs_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 2;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [ITER_W-1:0]    cnt_q, cnt_d;
  logic [2*ROOT_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]    root_q, root_d;
  logic [REM_W+1:0]     rem_sh;
  logic [REM_W+1:0]     trial;

  // One restoring step on the next pair of radicand bits
  always_comb begin
    rem_sh = {rem_q, rad_q[2*ROOT_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ITER_W'(ROOT_W - 1);
      rad_d  = {1'b0, radicand_i};
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[2*ROOT_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = REM_W'(rem_sh - trial);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(rem_sh);
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule
`default_nettype wire

// ----- sv/weighted_vertex_skinning_unit.sv -----
// ----------------------------------------------------------------------------
// weighted_vertex_skinning_unit
// Linear blend skinning: joint table writes and weighted vertex accumulation.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | word
//  in      | in  | in_valid_i/in_ready_o   | request type, joint, pos, quat, bias, last
//  out     | out | out_valid_o/out_ready_i | skinned vertex x, y, z, clip flag
//
// A weight runs the joint table read, two rotation multiply stages, the bias
// multiply and the saturating accumulate in sequence; a last weight adds the
// emit step.
// A joint write waits for the 15-step square root for w.
// The joint table is not cleared after reset; no start-up pass is needed.
// A last weight waits in the emit step while the output register is full.
`default_nettype none
`include "assert_macros.svh"
module weighted_vertex_skinning_unit #(
  parameter int unsigned MAX_JOINTS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               req_type_i,
  input  wire logic [5:0]         joint_index_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic [16:0]        bias_i,
  input  wire logic               last_weight_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      vert_x_o,
  output logic signed [31:0]      vert_y_o,
  output logic signed [31:0]      vert_z_o,
  output logic                    saturated_o
);
  import wvs_pkg::*;

  localparam int unsigned AW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int unsigned MW   = 51;
  localparam int unsigned UW   = 35;
  localparam int unsigned UUW  = 38;
  localparam int unsigned SW   = 42;
  localparam int unsigned PW   = 60;
  localparam int unsigned TW   = 44;
  localparam int unsigned ACCW = 48;

  wvs_state_e state_q, state_d;

  logic accept, mem_we, sqrt_start, emit_load;

  // Latched request
  logic signed [31:0] v_q [3];
  logic signed [15:0] qin_q [3];
  logic [16:0]        bias_q;
  logic               last_q;
  logic               idx_ok_q;
  logic [AW-1:0]      addr_q;

  // Joint table
  logic [ENTRY_W-1:0] mem_q [MAX_JOINTS];
  logic [ENTRY_W-1:0] rd_data_q;
  logic [ENTRY_W-1:0] entry;

  // Datapath
  logic signed [15:0]     q [3];
  logic signed [15:0]     w;
  logic signed [31:0]     p [3];
  logic signed [MW-1:0]   m_q [6];
  logic signed [MW-1:0]   uw_q [3];
  logic signed [UW-1:0]   u_q [3];
  logic signed [SW-1:0]   s_q [3];
  logic signed [PW-1:0]   prod_q [3];
  logic signed [ACCW-1:0] acc_q [3];
  logic                   sat_q;
  logic signed [UUW-1:0]  uu [3];
  logic signed [TW-1:0]   t [3];
  logic signed [ACCW:0]   sum [3];
  logic signed [ACCW-1:0] acc_new [3];
  logic [2:0]             acc_clip;

  // Square root for w
  logic [30:0]          sq_q [3];
  logic signed [31:0]   sqf [3];
  logic signed [33:0]   tt;
  logic                 tt_neg_q;
  wvs_sqrt_stat_t       sqrt_stat;
  logic [ROOT_W-1:0]    root;
  logic signed [15:0]   w_new;

  // Output register
  logic               out_valid_q;
  logic signed [31:0] vert_q [3];
  logic               out_sat_q;
  logic [2:0]         nar_clip;
  logic signed [31:0] nar [3];

  wvs_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (tt[RAD_W-1:0]),
    .stat_o     (sqrt_stat),
    .root_o     (root)
  );

  // Sequence one word at a time
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    sqrt_start = 1'b0;
    emit_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = (req_type_i == REQ_JOINT) ? ST_JSQ : ST_WMUL1;
        end
      end
      ST_JSQ:   state_d = ST_JSUM;
      ST_JSUM: begin
        sqrt_start = 1'b1;
        state_d    = ST_JROOT;
      end
      ST_JROOT: begin
        if (sqrt_stat.done) begin
          mem_we  = idx_ok_q;
          state_d = ST_IDLE;
        end
      end
      ST_WMUL1: state_d = ST_WU;
      ST_WU:    state_d = ST_WMUL2;
      ST_WMUL2: state_d = ST_WSUM;
      ST_WSUM:  state_d = ST_WMUL3;
      ST_WMUL3: state_d = ST_WACC;
      ST_WACC:  state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit_load = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the request word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q[0]   <= pos_x_i;
      v_q[1]   <= pos_y_i;
      v_q[2]   <= pos_z_i;
      qin_q[0] <= quat_x_i;
      qin_q[1] <= quat_y_i;
      qin_q[2] <= quat_z_i;
      bias_q   <= bias_i;
      last_q   <= last_weight_i;
      idx_ok_q <= ({26'd0, joint_index_i} < MAX_JOINTS);
      addr_q   <= AW'(joint_index_i);
    end
  end

  // Joint table: write on joint completion, read on accept
  assign w_new = tt_neg_q ? 16'sd0 : 16'sd0 - signed'({1'b0, root});

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= {w_new, qin_q[2], qin_q[1], qin_q[0], v_q[2], v_q[1], v_q[0]};
    end
    if (accept) begin
      rd_data_q <= mem_q[AW'(joint_index_i)];
    end
  end

  // Unpack the entry; an index beyond the table reads as zero
  assign entry = idx_ok_q ? rd_data_q : '0;
  assign p[0]  = entry[31:0];
  assign p[1]  = entry[63:32];
  assign p[2]  = entry[95:64];
  assign q[0]  = entry[111:96];
  assign q[1]  = entry[127:112];
  assign q[2]  = entry[143:128];
  assign w     = entry[159:144];

  // Squares and radicand for w
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sqf[k] = qin_q[k] * qin_q[k];
    end
    tt = 34'sd268435456 - signed'({3'b0, sq_q[0]}) - signed'({3'b0, sq_q[1]})
         - signed'({3'b0, sq_q[2]});
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_JSQ) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= sqf[k][30:0];
      end
    end
    if (state_q == ST_JSUM) begin
      tt_neg_q <= tt[33];
    end
  end

  // Second cross product, bias term shift, saturating accumulate, output narrowing
  always_comb begin
    uu[0] = UUW'((m_q[0] - m_q[1]) >>> 14);
    uu[1] = UUW'((m_q[2] - m_q[3]) >>> 14);
    uu[2] = UUW'((m_q[4] - m_q[5]) >>> 14);
    for (int k = 0; k < 3; k++) begin
      t[k]   = TW'(prod_q[k] >>> 16);
      sum[k] = (ACCW+1)'(acc_q[k]) + (ACCW+1)'(t[k]);
      acc_clip[k] = sum[k][ACCW] != sum[k][ACCW-1];
      if (acc_clip[k]) begin
        acc_new[k] = sum[k][ACCW] ? {1'b1, {(ACCW-1){1'b0}}} : {1'b0, {(ACCW-1){1'b1}}};
      end else begin
        acc_new[k] = sum[k][ACCW-1:0];
      end
      nar_clip[k] = acc_q[k][ACCW-1:31] != {(ACCW-31){acc_q[k][ACCW-1]}};
      if (nar_clip[k]) begin
        nar[k] = acc_q[k][ACCW-1] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        nar[k] = acc_q[k][31:0];
      end
    end
  end

  // Rotation stages, joint position sum and bias multiply
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_WMUL1: begin
        m_q[0] <= MW'(q[1]) * MW'(v_q[2]);
        m_q[1] <= MW'(q[2]) * MW'(v_q[1]);
        m_q[2] <= MW'(q[2]) * MW'(v_q[0]);
        m_q[3] <= MW'(q[0]) * MW'(v_q[2]);
        m_q[4] <= MW'(q[0]) * MW'(v_q[1]);
        m_q[5] <= MW'(q[1]) * MW'(v_q[0]);
      end
      ST_WU: begin
        u_q[0] <= UW'((m_q[0] - m_q[1]) >>> 14);
        u_q[1] <= UW'((m_q[2] - m_q[3]) >>> 14);
        u_q[2] <= UW'((m_q[4] - m_q[5]) >>> 14);
      end
      ST_WMUL2: begin
        m_q[0] <= MW'(q[1]) * MW'(u_q[2]);
        m_q[1] <= MW'(q[2]) * MW'(u_q[1]);
        m_q[2] <= MW'(q[2]) * MW'(u_q[0]);
        m_q[3] <= MW'(q[0]) * MW'(u_q[2]);
        m_q[4] <= MW'(q[0]) * MW'(u_q[1]);
        m_q[5] <= MW'(q[1]) * MW'(u_q[0]);
        for (int k = 0; k < 3; k++) begin
          uw_q[k] <= MW'(u_q[k]) * MW'(w);
        end
      end
      ST_WSUM: begin
        for (int k = 0; k < 3; k++) begin
          s_q[k] <= SW'(p[k]) + SW'(v_q[k])
                    + ((SW'(uw_q[k] >>> 14) + SW'(uu[k])) <<< 1);
        end
      end
      ST_WMUL3: begin
        for (int k = 0; k < 3; k++) begin
          prod_q[k] <= PW'(s_q[k]) * PW'(signed'({1'b0, bias_q}));
        end
      end
      default: begin
      end
    endcase
  end

  // Accumulators: add on each weight, clear on emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= '0;
      end
      sat_q <= 1'b0;
    end else if (state_q == ST_WACC) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= acc_new[k];
      end
      sat_q <= sat_q | (|acc_clip);
    end else if (emit_load) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= '0;
      end
      sat_q <= 1'b0;
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      for (int k = 0; k < 3; k++) begin
        vert_q[k] <= nar[k];
      end
      out_sat_q <= sat_q | (|nar_clip);
    end
  end

  assign out_valid_o = out_valid_q;
  assign vert_x_o    = vert_q[0];
  assign vert_y_o    = vert_q[1];
  assign vert_z_o    = vert_q[2];
  assign saturated_o = out_sat_q;

  `WVS_ASSERT(a_load_from_emit, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT && $past(last_q)))
  `WVS_ASSERT(a_acc_cleared, clk_i, rst_ni, $past(emit_load) |-> (acc_q[0] == '0 && acc_q[1] == '0 && acc_q[2] == '0 && !sat_q))
  `WVS_ASSERT(a_root_when_waiting, clk_i, rst_ni, sqrt_stat.done |-> (state_q == ST_JROOT && !sqrt_stat.busy))

endmodule
`default_nettype wire

// ----- tb/sv/tb_weighted_vertex_skinning_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weighted_vertex_skinning_unit
// Drives joint writes and vertex weights into the skinning unit and checks
// every emitted vertex against its typed row's values or a cycle-free
// predictor of fixed-point arithmetic, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_weighted_vertex_skinning_unit;
  import wvs_pkg::*;

  typedef struct {
    logic               kind;
    logic [5:0]         joint;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] qx, qy, qz;
    logic [16:0]        bias;
    logic               last;
  } skin_word_t;

  typedef struct {
    logic signed [31:0] vx, vy, vz;
    logic               sat;
  } vert_word_t;

  typedef struct {
    skin_word_t word;
    bit         typed;
    vert_word_t vert;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic req_type_i = REQ_JOINT;
  logic [5:0] joint_index_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [15:0] quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic [16:0] bias_i = '0;
  logic last_weight_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] vert_x_o, vert_y_o, vert_z_o;
  logic saturated_o;

  weighted_vertex_skinning_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: joint table and running sums
  logic signed [31:0] jnt_px[64], jnt_py[64], jnt_pz[64];
  logic signed [15:0] jnt_qx[64], jnt_qy[64], jnt_qz[64], jnt_qw[64];
  bit                 jnt_written[64];
  longint             sum_x, sum_y, sum_z;
  bit                 sum_clipped;

  vert_word_t vert_q[$];
  plan_row_t  plan_q[$];
  int         mismatches = 0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;

  function automatic longint root_floor(longint t);
    longint r, b;
    r = 0;
    b = 64'sd1 << 30;
    while (b > t) b = b >>> 2;
    while (b != 0) begin
      if (t >= r + b) begin
        t = t - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint clip_acc(longint s);
    if (s > 64'sd140737488355327) begin
      sum_clipped = 1'b1;
      return 64'sd140737488355327;
    end
    if (s < -64'sd140737488355328) begin
      sum_clipped = 1'b1;
      return -64'sd140737488355328;
    end
    return s;
  endfunction

  function automatic logic signed [31:0] narrow32(longint a, ref bit clip);
    if (a > 64'sd2147483647) begin
      clip = 1'b1;
      return 32'sh7fffffff;
    end
    if (a < -64'sd2147483648) begin
      clip = 1'b1;
      return 32'sh80000000;
    end
    return a[31:0];
  endfunction

  // Advance the predictor by one word; return 1 when a vertex comes out
  function automatic bit skin_predict(input skin_word_t w, output vert_word_t o);
    longint q[3], v[3], u[3], uu[3], p[3], t[3], qw, tt, r;
    bit clip;
    int j;
    j = int'(w.joint);
    v[0] = longint'(w.px);
    v[1] = longint'(w.py);
    v[2] = longint'(w.pz);
    o = '{default: '0};
    if (w.kind == REQ_JOINT) begin
      tt = (64'sd1 << 28) - longint'(w.qx) * w.qx - longint'(w.qy) * w.qy
           - longint'(w.qz) * w.qz;
      jnt_px[j] = w.px;
      jnt_py[j] = w.py;
      jnt_pz[j] = w.pz;
      jnt_qx[j] = w.qx;
      jnt_qy[j] = w.qy;
      jnt_qz[j] = w.qz;
      jnt_qw[j] = (tt < 0) ? 16'sd0 : 16'(-root_floor(tt));
      jnt_written[j] = 1'b1;
      return 1'b0;
    end
    q[0] = longint'(jnt_qx[j]);
    q[1] = longint'(jnt_qy[j]);
    q[2] = longint'(jnt_qz[j]);
    qw   = longint'(jnt_qw[j]);
    p[0] = longint'(jnt_px[j]);
    p[1] = longint'(jnt_py[j]);
    p[2] = longint'(jnt_pz[j]);
    u[0] = (q[1] * v[2] - q[2] * v[1]) >>> 14;
    u[1] = (q[2] * v[0] - q[0] * v[2]) >>> 14;
    u[2] = (q[0] * v[1] - q[1] * v[0]) >>> 14;
    uu[0] = (q[1] * u[2] - q[2] * u[1]) >>> 14;
    uu[1] = (q[2] * u[0] - q[0] * u[2]) >>> 14;
    uu[2] = (q[0] * u[1] - q[1] * u[0]) >>> 14;
    for (int k = 0; k < 3; k++) begin
      r = v[k] + 2 * (((u[k] * qw) >>> 14) + uu[k]);
      t[k] = ((p[k] + r) * longint'(w.bias)) >>> 16;
    end
    sum_x = clip_acc(sum_x + t[0]);
    sum_y = clip_acc(sum_y + t[1]);
    sum_z = clip_acc(sum_z + t[2]);
    if (!w.last) return 1'b0;
    clip = sum_clipped;
    o.vx = narrow32(sum_x, clip);
    o.vy = narrow32(sum_y, clip);
    o.vz = narrow32(sum_z, clip);
    o.sat = clip;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    sum_clipped = 1'b0;
    return 1'b1;
  endfunction

  function automatic skin_word_t make_word(logic kind, int j, longint x, longint y,
                                           longint z, int a, int b, int c, int bias,
                                           bit last);
    skin_word_t w;
    w.kind = kind;
    w.joint = 6'(j);
    w.px = 32'(x);
    w.py = 32'(y);
    w.pz = 32'(z);
    w.qx = 16'(a);
    w.qy = 16'(b);
    w.qz = 16'(c);
    w.bias = 17'(bias);
    w.last = last;
    return w;
  endfunction

  function automatic void add_row(skin_word_t w, bit typed = 0, int vx = 0, int vy = 0,
                                  int vz = 0, bit sat = 0);
    plan_row_t row;
    row.word = w;
    row.typed = typed;
    row.vert = '{vx, vy, vz, sat};
    plan_q = {plan_q, row};
  endfunction

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(2097152)) - 32'sd1048576;
      default: return $signed($urandom_range(33554432)) - 32'sd16777216;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_quat();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(32768)) - 32'sd16384);
      default: return 16'($signed($urandom_range(18000)) - 32'sd9000);
    endcase
  endfunction

  function automatic logic [16:0] rand_bias();
    return ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
  endfunction

  // Offer one word; hold it until accepted, then book its expectation
  task automatic send_word(plan_row_t row);
    vert_word_t pv;
    if (!calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= row.word.kind;
    joint_index_i <= row.word.joint;
    pos_x_i       <= row.word.px;
    pos_y_i       <= row.word.py;
    pos_z_i       <= row.word.pz;
    quat_x_i      <= row.word.qx;
    quat_y_i      <= row.word.qy;
    quat_z_i      <= row.word.qz;
    bias_i        <= row.word.bias;
    last_weight_i <= row.word.last;
    do @(posedge clk_i); while (!in_ready_o);
    if (skin_predict(row.word, pv)) begin
      if (row.typed) pv = row.vert;
      vert_q = {vert_q, pv};
    end
  endtask

  // Output side: check each accepted vertex, then pick the next ready
  int hold_left = 0;
  always @(posedge clk_i) begin
    vert_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (vert_q.size() == 0) begin
        $error("unexpected vertex x=%0d y=%0d z=%0d", vert_x_o, vert_y_o, vert_z_o);
        mismatches++;
      end else begin
        e = vert_q.pop_front();
        if (vert_x_o !== e.vx) begin
          $error("vert_x expected %0d got %0d", e.vx, vert_x_o);
          mismatches++;
        end
        if (vert_y_o !== e.vy) begin
          $error("vert_y expected %0d got %0d", e.vy, vert_y_o);
          mismatches++;
        end
        if (vert_z_o !== e.vz) begin
          $error("vert_z expected %0d got %0d", e.vz, vert_z_o);
          mismatches++;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated expected %0b got %0b", e.sat, saturated_o);
          mismatches++;
        end
      end
    end
    if (hold_req && hold_left == 0) hold_left = 300;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_req = 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 34);
    end
  end

  initial begin
    int j, n, cnt;
    bit held, drained;
    plan_row_t row;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    sum_clipped = 1'b0;
    held = 1'b0;
    drained = 1'b0;
    foreach (jnt_written[i]) jnt_written[i] = 1'b0;

    // Directed rows: identity joints, extremes, degenerate w, wide fields
    add_row(make_word(REQ_JOINT, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(make_word(REQ_WEIGHT, 0, 100, -200, 300, 0, 0, 0, 65536, 1), 1, 100, -200, 300, 0);
    add_row(make_word(REQ_JOINT, 1, 2147483647, -2147483648, 0, 0, 0, 0, 65536, 0));
    add_row(make_word(REQ_WEIGHT, 1, 2147483647, -2147483648, 0, 0, 0, 0, 65536, 1),
            1, 2147483647, -2147483648, 0, 1);
    add_row(make_word(REQ_WEIGHT, 0, 5, 5, 5, -1, -1, -1, 0, 1), 1, 0, 0, 0, 0);
    add_row(make_word(REQ_JOINT, 2, 65536, -65536, 1, 16384, 0, 0, 0, 0));
    add_row(make_word(REQ_JOINT, 3, -1, 0, 7, -16384, -16384, -16384, 0, 0));
    add_row(make_word(REQ_JOINT, 63, 12345, -54321, 2147483647, 32767, -32768, 1, 131071, 1));
    add_row(make_word(REQ_JOINT, 4, -65536, 131072, -196608, 8192, 8192, 8192, 0, 0));
    add_row(make_word(REQ_WEIGHT, 2, 65536, 65536, 65536, 0, 0, 0, 65536, 0));
    add_row(make_word(REQ_WEIGHT, 3, -2147483648, 2147483647, -1, 0, 0, 0, 131071, 0));
    add_row(make_word(REQ_WEIGHT, 63, 1, -1, 65536, 32767, -32768, -1, 65536, 1));
    add_row(make_word(REQ_WEIGHT, 4, 98304, -32768, 7, 0, 0, 0, 32768, 0));
    add_row(make_word(REQ_WEIGHT, 4, -2147483648, -2147483648, -2147483648, 0, 0, 0,
                      131071, 1));
    add_row(make_word(REQ_WEIGHT, 2, 1, 2, 3, 0, 0, 0, 1, 1));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    while (plan_q.size() != 0) send_word(plan_q.pop_front());

    // Random part: mostly well-formed vertices over written joints
    cnt = 0;
    while (cnt < 500) begin
      calm = (cnt >= 200 && cnt < 300);
      if (cnt >= 120 && !held) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (cnt >= 350 && !drained) begin
        drained = 1'b1;
        in_valid_i <= 1'b0;
        wait (vert_q.size() == 0);
        @(posedge clk_i);
      end
      if ($urandom_range(99) < 20) begin
        row.word = make_word(REQ_JOINT, $urandom_range(63), rand_pos(), rand_pos(),
                             rand_pos(), rand_quat(), rand_quat(), rand_quat(),
                             rand_bias(), $urandom_range(1));
        row.typed = 0;
        send_word(row);
        cnt++;
      end else begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          do j = $urandom_range(63); while (!jnt_written[j]);
          row.word = make_word(REQ_WEIGHT, j, rand_pos(), rand_pos(), rand_pos(),
                               rand_quat(), rand_quat(), rand_quat(), rand_bias(),
                               (k == n - 1) || ($urandom_range(19) == 0));
          row.typed = 0;
          send_word(row);
          cnt++;
        end
      end
    end
    // Close any open vertex so every sum is drained
    row.word = make_word(REQ_WEIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    row.typed = 0;
    send_word(row);
    in_valid_i <= 1'b0;
    calm = 1'b0;

    wait (vert_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Drop out if the run hangs
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/wvs_pkg.sv
sv/wvs_sqrt.sv
sv/weighted_vertex_skinning_unit.sv
tb/sv/tb_weighted_vertex_skinning_unit.sv
